@@ rtl/core/cde_pkg.sv @@
// Shared types and command codes for the circular deque engine.
package cde_pkg;

   // Command codes carried on req_command
   localparam logic [2:0] CMD_INS_FRONT = 3'd0;
   localparam logic [2:0] CMD_INS_REAR  = 3'd1;
   localparam logic [2:0] CMD_DEL_FRONT = 3'd2;
   localparam logic [2:0] CMD_DEL_REAR  = 3'd3;
   localparam logic [2:0] CMD_QUERY     = 3'd4;

   // Width of the size register
   localparam int unsigned SIZE_BITS = 6;
   localparam logic [SIZE_BITS-1:0] SIZE_RESET = 6'd63;

   typedef enum logic [0:0] {
      CDE_IDLE,
      CDE_FETCH
   } cde_state_type;

endpackage

@@ rtl/core/circular_deque_engine.sv @@
// Circular deque engine: bounded double-ended queue held in a ring of slots.
// Result strobe in the cycle after the start transfer; a delete that leaves entries
//   waits for the fetch state, as the new end value is the registered memory read.
// Throughput: one command per cycle when not busy; busy is high in the fetch state.
// Reset (synchronous): deque empty, size 63, no result pending; slots not cleared.
// The receiver cannot stall: each result is shown for one cycle only.
module circular_deque_engine #(
   parameter int unsigned SLOTS      = 64,
   parameter int unsigned VALUE_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   // command transfer
   input  logic                             start,
   output logic                             busy,
   input  logic [2:0]                       req_command,
   input  logic signed [VALUE_BITS-1:0]     req_value,
   // result transfer
   output logic                             rsp_valid,
   output logic                             rsp_ok,
   output logic signed [VALUE_BITS-1:0]     rsp_front_value,
   output logic signed [VALUE_BITS-1:0]     rsp_rear_value,
   output logic                             rsp_is_empty,
   output logic                             rsp_is_full,
   // size register
   input  logic                             csr_we,
   input  logic [cde_pkg::SIZE_BITS-1:0]    csr_wdata
);

   // Index width covers the store; ring length must also hold size + 1
   localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int unsigned LEN_W = (IDX_W + 1 > cde_pkg::SIZE_BITS + 1) ?
                                   IDX_W + 1 : cde_pkg::SIZE_BITS + 1;

   // ---------------------------------------------------------------------
   // State
   // ---------------------------------------------------------------------
   cde_pkg::cde_state_type        state_ff, state_in;
   logic [cde_pkg::SIZE_BITS-1:0] size_ff;
   logic [IDX_W-1:0]              head_ff, head_in;
   logic [IDX_W-1:0]              tail_ff, tail_in;

   // Cached end values: slots at head and at tail - 1; one stale in the fetch state
   logic [VALUE_BITS-1:0]         front_ff, front_in;
   logic [VALUE_BITS-1:0]         rear_ff, rear_in;

   // Result flags and strobe
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_ok_ff;
   logic                          rsp_empty_ff;
   logic                          rsp_full_ff;

   // Which end the pending read refills
   logic                          fetch_rear_ff, fetch_rear_in;

   // Slot memory, one write and one registered read port
   logic [VALUE_BITS-1:0]         slot_mem [SLOTS];
   logic [VALUE_BITS-1:0]         mem_rd_ff;
   logic                          mem_we;
   logic [IDX_W-1:0]              mem_waddr;
   logic [IDX_W-1:0]              mem_raddr;

   logic                          accept;
   logic                          cmd_ok;
   logic                          need_fetch;
   logic                          empty_cur, full_cur;
   logic                          empty_new, full_new;
   logic [LEN_W-1:0]              ring_len;
   logic [LEN_W-1:0]              len_raw;

   // ---------------------------------------------------------------------
   // Ring arithmetic
   // ---------------------------------------------------------------------
   function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] idx,
                                                input logic [LEN_W-1:0] len);
      logic [LEN_W-1:0] nxt;
      nxt = LEN_W'(idx) + LEN_W'(1);
      return (nxt >= len) ? '0 : nxt[IDX_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] idx,
                                                  input logic [LEN_W-1:0] len);
      logic [LEN_W-1:0] last;
      last = len - LEN_W'(1);
      return (idx == '0) ? last[IDX_W-1:0] : idx - IDX_W'(1);
   endfunction

   // Ring has size + 1 slots, clamped to the store depth
   assign len_raw  = LEN_W'(size_ff) + LEN_W'(1);
   assign ring_len = (len_raw > LEN_W'(SLOTS)) ? LEN_W'(SLOTS) : len_raw;

   assign accept    = start && !busy;
   assign empty_cur = (head_ff == tail_ff);
   assign full_cur  = (step_up(tail_ff, ring_len) == head_ff);

   // ---------------------------------------------------------------------
   // Command decode: pointer moves, memory access, cache update
   // ---------------------------------------------------------------------
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      front_in      = front_ff;
      rear_in       = rear_ff;
      cmd_ok        = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = tail_ff;
      mem_raddr     = head_ff;
      fetch_rear_in = fetch_rear_ff;
      need_fetch    = 1'b0;

      if (accept) begin
         unique case (req_command)
            cde_pkg::CMD_INS_FRONT: begin
               if (!full_cur) begin
                  head_in   = step_down(head_ff, ring_len);
                  mem_we    = 1'b1;
                  mem_waddr = head_in;
                  front_in  = req_value;
                  if (empty_cur) begin
                     rear_in = req_value;
                  end
                  cmd_ok = 1'b1;
               end
            end
            cde_pkg::CMD_INS_REAR: begin
               if (!full_cur) begin
                  tail_in   = step_up(tail_ff, ring_len);
                  mem_we    = 1'b1;
                  mem_waddr = tail_ff;
                  rear_in   = req_value;
                  if (empty_cur) begin
                     front_in = req_value;
                  end
                  cmd_ok = 1'b1;
               end
            end
            cde_pkg::CMD_DEL_FRONT: begin
               if (!empty_cur) begin
                  head_in       = step_up(head_ff, ring_len);
                  mem_raddr     = head_in;
                  fetch_rear_in = 1'b0;
                  cmd_ok        = 1'b1;
               end
            end
            cde_pkg::CMD_DEL_REAR: begin
               if (!empty_cur) begin
                  tail_in       = step_down(tail_ff, ring_len);
                  mem_raddr     = step_down(tail_in, ring_len);
                  fetch_rear_in = 1'b1;
                  cmd_ok        = 1'b1;
               end
            end
            cde_pkg::CMD_QUERY: begin
               cmd_ok = 1'b1;
            end
            default: begin
               // unassigned code: state kept, refused
            end
         endcase
      end

      // A delete that leaves entries needs the new end slot from memory
      if (accept && cmd_ok && (head_in != tail_in) &&
          ((req_command == cde_pkg::CMD_DEL_FRONT) ||
           (req_command == cde_pkg::CMD_DEL_REAR))) begin
         need_fetch = 1'b1;
      end

      // Refill the cache from the registered read in the fetch cycle
      if (state_ff == cde_pkg::CDE_FETCH) begin
         if (fetch_rear_ff) begin
            rear_in = mem_rd_ff;
         end else begin
            front_in = mem_rd_ff;
         end
      end
   end

   assign empty_new = (head_in == tail_in);
   assign full_new  = (step_up(tail_in, ring_len) == head_in);

   // ---------------------------------------------------------------------
   // Sequencer: next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cde_pkg::CDE_IDLE: begin
            if (need_fetch) begin
               state_in = cde_pkg::CDE_FETCH;
            end
         end
         cde_pkg::CDE_FETCH: begin
            state_in = cde_pkg::CDE_IDLE;
         end
         default: begin
            state_in = cde_pkg::CDE_IDLE;
         end
      endcase
   end

   // Sequencer: outputs
   always_comb begin
      busy         = 1'b0;
      rsp_valid_in = 1'b0;
      unique case (state_ff)
         cde_pkg::CDE_IDLE: begin
            rsp_valid_in = start && !need_fetch;
         end
         cde_pkg::CDE_FETCH: begin
            busy         = 1'b1;
            rsp_valid_in = 1'b1;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cde_pkg::CDE_IDLE;
         size_ff      <= cde_pkg::SIZE_RESET;
         head_ff      <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            // size write always empties the deque
            size_ff <= csr_wdata;
            head_ff <= '0;
            tail_ff <= '0;
         end else begin
            head_ff <= head_in;
            tail_ff <= tail_in;
         end
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      front_ff      <= front_in;
      rear_ff       <= rear_in;
      fetch_rear_ff <= fetch_rear_in;
      if (accept) begin
         rsp_ok_ff    <= cmd_ok;
         rsp_empty_ff <= empty_new;
         rsp_full_ff  <= full_new;
      end
   end

   // Slot memory: written only on an accepted insert, never in the fetch cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= req_value;
      end
      mem_rd_ff <= slot_mem[mem_raddr];
   end

   // ---------------------------------------------------------------------
   // Result ports: empty deque reads as all ones at both ends
   // ---------------------------------------------------------------------
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_is_empty    = rsp_empty_ff;
   assign rsp_is_full     = rsp_full_ff;
   assign rsp_front_value = rsp_empty_ff ? '1 : front_ff;
   assign rsp_rear_value  = rsp_empty_ff ? '1 : rear_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // The fetch cycle only ever follows an accepted delete
   a_fetch_after_accept : assert property (@(posedge clock) disable iff (reset)
      (state_ff == cde_pkg::CDE_FETCH) |-> $past(accept))
      else $error("fetch cycle without a preceding delete transfer");

   // Pointers never leave the ring
   a_ptr_in_ring : assert property (@(posedge clock) disable iff (reset)
      (LEN_W'(head_ff) < ring_len) && (LEN_W'(tail_ff) < ring_len))
      else $error("deque pointer outside ring");

   // A reported empty deque matches the pointers while the result is shown
   a_empty_matches : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_empty_ff) |-> (head_ff == tail_ff))
      else $error("empty flag disagrees with pointers");

endmodule
